[src/spse_pkg.sv]
package spse_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int MAX_RESULTS  = 32;
  localparam int DATA_W       = 32;
  localparam int NRES_W       = $clog2(MAX_RESULTS + 1);

  // request codes
  localparam logic [2:0] REQ_ADD       = 3'd0;
  localparam logic [2:0] REQ_REMOVE    = 3'd1;
  localparam logic [2:0] REQ_PRINT     = 3'd2;
  localparam logic [2:0] REQ_UNION     = 3'd3;
  localparam logic [2:0] REQ_INTERSECT = 3'd4;

  // result status codes
  localparam logic [2:0] STAT_ELEMENT = 3'd0;
  localparam logic [2:0] STAT_ADDED   = 3'd1;
  localparam logic [2:0] STAT_PRESENT = 3'd2;
  localparam logic [2:0] STAT_REMOVED = 3'd3;
  localparam logic [2:0] STAT_ABSENT  = 3'd4;
  localparam logic [2:0] STAT_FULL    = 3'd5;

  typedef struct packed {
    logic [2:0]               req_type;
    logic                     set_select;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] element;
    logic [2:0]               status;
    logic                     last;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_PRINT,
    S_MERGE_START,
    S_MERGE,
    S_FINISH
  } state_t;

endpackage

[src/spse_mem.sv]
module spse_mem #(
  parameter int DEPTH = spse_pkg::CAPACITY_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          wen,
  input  logic [AW-1:0]                 waddr,
  input  logic [spse_pkg::DATA_W-1:0]   wdata,
  input  logic [AW-1:0]                 raddr,
  output logic [spse_pkg::DATA_W-1:0]   rdata
);

  logic [spse_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[src/spse_ctrl.sv]
module spse_ctrl #(
  parameter int CAPACITY = spse_pkg::CAPACITY_DEF,
  parameter int IW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  spse_pkg::req_t              req,
  output logic                        busy,
  output logic                        strobe,
  output spse_pkg::result_t           result,
  output logic [IW-1:0]               x_raddr,
  output logic                        x_wen,
  output logic [IW-1:0]               x_waddr,
  output logic [spse_pkg::DATA_W-1:0] x_wdata,
  input  logic [spse_pkg::DATA_W-1:0] x_rdata,
  output logic [IW-1:0]               y_raddr,
  output logic                        y_wen,
  output logic [IW-1:0]               y_waddr,
  output logic [spse_pkg::DATA_W-1:0] y_wdata,
  input  logic [spse_pkg::DATA_W-1:0] y_rdata
);

  spse_pkg::state_t state, state_next;

  logic [CW-1:0] cnt_x, cnt_x_next;
  logic [CW-1:0] cnt_y, cnt_y_next;
  logic          sel, sel_next;
  logic [2:0]    op, op_next;
  logic signed [spse_pkg::DATA_W-1:0] val, val_next;
  logic [CW-1:0] rd_idx, rd_idx_next;   // scan pointer, also shift pointer
  logic          pend, pend_next;       // a read is in flight
  logic [CW-1:0] cmp_idx, cmp_idx_next; // index of the entry in rdata
  logic [CW-1:0] pos, pos_next;
  logic [CW-1:0] wdest, wdest_next;
  logic [CW-1:0] i, i_next;
  logic [CW-1:0] j, j_next;
  logic [spse_pkg::NRES_W-1:0] nres, nres_next;
  logic              hold_valid, hold_valid_next;
  spse_pkg::result_t hold, hold_next;
  logic              strobe_next;
  spse_pkg::result_t result_next;

  // per-cycle controls
  logic                               prod;
  logic signed [spse_pkg::DATA_W-1:0] prod_elem;
  logic [2:0]                         prod_status;
  logic                               wen_c;
  logic [IW-1:0]                      waddr_c;
  logic [spse_pkg::DATA_W-1:0]        wdata_c;
  logic [IW-1:0]                      rd_addr_c;
  logic [CW-1:0]                      cnt_sel;
  logic signed [spse_pkg::DATA_W-1:0] rdata_sel;
  logic signed [spse_pkg::DATA_W-1:0] a;
  logic signed [spse_pkg::DATA_W-1:0] b;
  logic [CW:0]                        rd_inc;
  logic                               xa;
  logic                               yb;
  logic                               add_decide;

  assign busy      = (state != spse_pkg::S_IDLE);
  assign cnt_sel   = sel ? cnt_y : cnt_x;
  assign rdata_sel = sel ? $signed(y_rdata) : $signed(x_rdata);
  assign a         = $signed(x_rdata);
  assign b         = $signed(y_rdata);
  assign rd_inc    = {1'b0, rd_idx} + (CW+1)'(1);
  assign xa        = (i < cnt_x);
  assign yb        = (j < cnt_y);

  assign x_wen   = wen_c & ~sel;
  assign y_wen   = wen_c & sel;
  assign x_waddr = waddr_c;
  assign y_waddr = waddr_c;
  assign x_wdata = wdata_c;
  assign y_wdata = wdata_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= spse_pkg::S_IDLE;
      cnt_x      <= '0;
      cnt_y      <= '0;
      pend       <= 1'b0;
      nres       <= '0;
      hold_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      state      <= state_next;
      cnt_x      <= cnt_x_next;
      cnt_y      <= cnt_y_next;
      pend       <= pend_next;
      nres       <= nres_next;
      hold_valid <= hold_valid_next;
      strobe     <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    sel     <= sel_next;
    op      <= op_next;
    val     <= val_next;
    rd_idx  <= rd_idx_next;
    cmp_idx <= cmp_idx_next;
    pos     <= pos_next;
    wdest   <= wdest_next;
    i       <= i_next;
    j       <= j_next;
    hold    <= hold_next;
    result  <= result_next;
  end

  always_comb begin
    state_next      = state;
    cnt_x_next      = cnt_x;
    cnt_y_next      = cnt_y;
    sel_next        = sel;
    op_next         = op;
    val_next        = val;
    rd_idx_next     = rd_idx;
    pend_next       = pend;
    cmp_idx_next    = cmp_idx;
    pos_next        = pos;
    wdest_next      = wdest;
    i_next          = i;
    j_next          = j;
    nres_next       = nres;
    hold_valid_next = hold_valid;
    hold_next       = hold;
    strobe_next     = 1'b0;
    result_next     = result;
    prod            = 1'b0;
    prod_elem       = '0;
    prod_status     = spse_pkg::STAT_ELEMENT;
    wen_c           = 1'b0;
    waddr_c         = wdest[IW-1:0];
    wdata_c         = rdata_sel;
    rd_addr_c       = rd_idx[IW-1:0];
    add_decide      = 1'b0;
    x_raddr         = rd_addr_c;
    y_raddr         = rd_addr_c;

    unique case (state)
      spse_pkg::S_IDLE: begin
        if (start) begin
          sel_next    = req.set_select;
          op_next     = req.req_type;
          val_next    = req.value;
          rd_idx_next = '0;
          pend_next   = 1'b0;
          nres_next   = '0;
          i_next      = '0;
          j_next      = '0;
          unique case (req.req_type) inside
            spse_pkg::REQ_ADD, spse_pkg::REQ_REMOVE: state_next = spse_pkg::S_SEARCH;
            spse_pkg::REQ_PRINT:                     state_next = spse_pkg::S_PRINT;
            spse_pkg::REQ_UNION, spse_pkg::REQ_INTERSECT: begin
              state_next = spse_pkg::S_MERGE_START;
            end
            default: state_next = spse_pkg::S_IDLE;
          endcase
        end
      end

      spse_pkg::S_SEARCH: begin
        // pipelined scan: issue a read per cycle, compare the previous one
        if (rd_idx < cnt_sel) begin
          rd_idx_next  = rd_idx + CW'(1);
          pend_next    = 1'b1;
          cmp_idx_next = rd_idx;
        end else begin
          pend_next = 1'b0;
        end
        if (pend) begin
          if (rdata_sel == val) begin
            pend_next = 1'b0;
            if (op == spse_pkg::REQ_ADD) begin
              prod        = 1'b1;
              prod_status = spse_pkg::STAT_PRESENT;
              state_next  = spse_pkg::S_FINISH;
            end else begin
              pos_next    = cmp_idx;
              rd_idx_next = cmp_idx;
              state_next  = spse_pkg::S_SHIFT_DN;
            end
          end else if (val < rdata_sel) begin
            // sorted: value can not be further up
            pend_next = 1'b0;
            if (op == spse_pkg::REQ_ADD) begin
              pos_next   = cmp_idx;
              add_decide = 1'b1;
            end else begin
              prod        = 1'b1;
              prod_status = spse_pkg::STAT_ABSENT;
              state_next  = spse_pkg::S_FINISH;
            end
          end
        end else if (rd_idx >= cnt_sel) begin
          pend_next = 1'b0;
          if (op == spse_pkg::REQ_ADD) begin
            pos_next   = cnt_sel;
            add_decide = 1'b1;
          end else begin
            prod        = 1'b1;
            prod_status = spse_pkg::STAT_ABSENT;
            state_next  = spse_pkg::S_FINISH;
          end
        end
        if (add_decide) begin
          if (cnt_sel == CW'(CAPACITY)) begin
            prod        = 1'b1;
            prod_status = spse_pkg::STAT_FULL;
            state_next  = spse_pkg::S_FINISH;
          end else begin
            rd_idx_next = cnt_sel;
            state_next  = spse_pkg::S_SHIFT_UP;
          end
        end
      end

      spse_pkg::S_SHIFT_UP: begin
        // read k-1 while the entry read last cycle lands at k+1
        if (pend) begin
          wen_c = 1'b1;
        end
        if (rd_idx > pos) begin
          rd_addr_c   = IW'(rd_idx - CW'(1));
          x_raddr     = rd_addr_c;
          y_raddr     = rd_addr_c;
          pend_next   = 1'b1;
          wdest_next  = rd_idx;
          rd_idx_next = rd_idx - CW'(1);
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            wen_c       = 1'b1;
            waddr_c     = pos[IW-1:0];
            wdata_c     = val;
            prod        = 1'b1;
            prod_status = spse_pkg::STAT_ADDED;
            state_next  = spse_pkg::S_FINISH;
            if (sel) begin
              cnt_y_next = cnt_y + CW'(1);
            end else begin
              cnt_x_next = cnt_x + CW'(1);
            end
          end
        end
      end

      spse_pkg::S_SHIFT_DN: begin
        if (pend) begin
          wen_c = 1'b1;
        end
        if (rd_inc < {1'b0, cnt_sel}) begin
          rd_addr_c   = rd_inc[IW-1:0];
          x_raddr     = rd_addr_c;
          y_raddr     = rd_addr_c;
          pend_next   = 1'b1;
          wdest_next  = rd_idx;
          rd_idx_next = rd_inc[CW-1:0];
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            prod        = 1'b1;
            prod_status = spse_pkg::STAT_REMOVED;
            state_next  = spse_pkg::S_FINISH;
            if (sel) begin
              cnt_y_next = cnt_y - CW'(1);
            end else begin
              cnt_x_next = cnt_x - CW'(1);
            end
          end
        end
      end

      spse_pkg::S_PRINT: begin
        if (rd_idx < cnt_sel) begin
          rd_idx_next = rd_idx + CW'(1);
          pend_next   = 1'b1;
        end else begin
          pend_next = 1'b0;
        end
        if (pend) begin
          prod      = 1'b1;
          prod_elem = rdata_sel;
        end else if (rd_idx >= cnt_sel) begin
          state_next = spse_pkg::S_FINISH;
        end
      end

      spse_pkg::S_MERGE_START: begin
        x_raddr    = i[IW-1:0];
        y_raddr    = j[IW-1:0];
        state_next = spse_pkg::S_MERGE;
      end

      spse_pkg::S_MERGE: begin
        // heads x[i], y[j] sit in the read registers; next heads read now
        if (xa && yb) begin
          if (a < b) begin
            prod   = (op == spse_pkg::REQ_UNION);
            i_next = i + CW'(1);
          end else if (b < a) begin
            prod   = (op == spse_pkg::REQ_UNION);
            j_next = j + CW'(1);
          end else begin
            prod   = 1'b1;
            i_next = i + CW'(1);
            j_next = j + CW'(1);
          end
          prod_elem = (b < a) ? b : a;
        end else if (xa && op == spse_pkg::REQ_UNION) begin
          prod      = 1'b1;
          prod_elem = a;
          i_next    = i + CW'(1);
        end else if (yb && op == spse_pkg::REQ_UNION) begin
          prod      = 1'b1;
          prod_elem = b;
          j_next    = j + CW'(1);
        end else begin
          state_next = spse_pkg::S_FINISH;
        end
        x_raddr = i_next[IW-1:0];
        y_raddr = j_next[IW-1:0];
      end

      spse_pkg::S_FINISH: begin
        // flush the held result, marked as the final one
        if (hold_valid) begin
          strobe_next      = 1'b1;
          result_next      = hold;
          result_next.last = 1'b1;
        end
        hold_valid_next = 1'b0;
        state_next      = spse_pkg::S_IDLE;
      end

      default: state_next = spse_pkg::S_IDLE;
    endcase

    if (state == spse_pkg::S_SHIFT_UP || state == spse_pkg::S_SHIFT_DN) begin
      x_raddr = rd_addr_c;
      y_raddr = rd_addr_c;
    end

    // one result is held back so the final one can carry last
    if (prod) begin
      if (hold_valid) begin
        strobe_next = 1'b1;
        result_next = hold;
      end
      hold_next.element = prod_elem;
      hold_next.status  = prod_status;
      hold_next.last    = 1'b0;
      hold_valid_next   = 1'b1;
      nres_next         = nres + spse_pkg::NRES_W'(1);
      if (nres == spse_pkg::NRES_W'(spse_pkg::MAX_RESULTS - 1)) begin
        pend_next  = 1'b0;
        state_next = spse_pkg::S_FINISH;
      end
    end
  end

endmodule

[src/sorted_pair_set_engine_top.sv]
// Add and remove run a pipelined scan, then an insertion or removal shift, one entry a cycle,
// before the status result. Print streams the selected set in order; union and intersect
// take one merge step a cycle. One request at a time; the next start can transfer as the
// final result goes out.
// Reset clears both counts and the controller; set memories are not cleared.
// Results appear one per strobe cycle; the receiver cannot stall.
module sorted_pair_set_engine_top #(
  parameter int CAPACITY = spse_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  spse_pkg::req_t    req,
  output logic              busy,
  output logic              strobe,
  output spse_pkg::result_t result
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [IW-1:0]               x_raddr, x_waddr, y_raddr, y_waddr;
  logic                        x_wen, y_wen;
  logic [spse_pkg::DATA_W-1:0] x_wdata, x_rdata, y_wdata, y_rdata;

  spse_ctrl #(
    .CAPACITY (CAPACITY),
    .IW       (IW),
    .CW       (CW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .req     (req),
    .busy    (busy),
    .strobe  (strobe),
    .result  (result),
    .x_raddr (x_raddr),
    .x_wen   (x_wen),
    .x_waddr (x_waddr),
    .x_wdata (x_wdata),
    .x_rdata (x_rdata),
    .y_raddr (y_raddr),
    .y_wen   (y_wen),
    .y_waddr (y_waddr),
    .y_wdata (y_wdata),
    .y_rdata (y_rdata)
  );

  spse_mem #(
    .DEPTH (CAPACITY),
    .AW    (IW)
  ) u_mem_x (
    .clk   (clk),
    .wen   (x_wen),
    .waddr (x_waddr),
    .wdata (x_wdata),
    .raddr (x_raddr),
    .rdata (x_rdata)
  );

  spse_mem #(
    .DEPTH (CAPACITY),
    .AW    (IW)
  ) u_mem_y (
    .clk   (clk),
    .wen   (y_wen),
    .waddr (y_waddr),
    .wdata (y_wdata),
    .raddr (y_raddr),
    .rdata (y_rdata)
  );

`ifndef SYNTHESIS
  a_status_is_final: assert property (@(posedge clk) disable iff (rst)
    strobe && result.status != spse_pkg::STAT_ELEMENT |-> result.last)
    else $error("status result without last");

  a_status_no_element: assert property (@(posedge clk) disable iff (rst)
    strobe && result.status != spse_pkg::STAT_ELEMENT |-> result.element == '0)
    else $error("status result with nonzero element");

  a_last_ends_request: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last |-> !busy)
    else $error("final result while request still running");

  a_valid_req_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (req.req_type == spse_pkg::REQ_ADD
      || req.req_type == spse_pkg::REQ_REMOVE || req.req_type == spse_pkg::REQ_PRINT
      || req.req_type == spse_pkg::REQ_UNION || req.req_type == spse_pkg::REQ_INTERSECT)
    |=> busy)
    else $error("accepted request did not start");
`endif

endmodule

[tb/tb_sorted_pair_set_engine_top.sv]
module tb_sorted_pair_set_engine_top;

  localparam int CAP            = spse_pkg::CAPACITY_DEF;
  localparam int POOL_N         = 24;
  localparam int PHASES         = 9;
  localparam int PHASE_ITEMS    = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DIR_N          = 22;

  // request codes the block must ignore
  localparam logic [2:0] REQ_RSVD5 = 3'd5;
  localparam logic [2:0] REQ_RSVD6 = 3'd6;
  localparam logic [2:0] REQ_RSVD7 = 3'd7;

  // stimulus mix per phase
  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 2;

  typedef struct packed {
    logic       typed;  // expectation written in the table
    logic       none;   // typed: no results at all
    logic [2:0] stat;   // typed: single status result
  } tag_t;

  typedef struct packed {
    spse_pkg::req_t r;
    tag_t           tag;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  spse_pkg::req_t    req = '0;
  logic              busy;
  logic              strobe;
  spse_pkg::result_t result;

  // predicted set contents
  logic signed [31:0] set_mem [2][CAP];
  int                 set_cnt [2];

  spse_pkg::result_t pending_results [$];
  spse_pkg::result_t request_results [$];
  tag_t              request_tags [$];
  int                mismatch_count = 0;
  int                idle_cycles = 0;
  tag_t              cur_tag;
  logic signed [31:0] value_pool [POOL_N];

  dir_row_t dir_tbl [DIR_N] = '{
    '{'{spse_pkg::REQ_PRINT, 1'b0, 32'h0}, '{1'b1, 1'b1, spse_pkg::STAT_ELEMENT}},
    '{'{spse_pkg::REQ_UNION, 1'b0, 32'h0}, '{1'b1, 1'b1, spse_pkg::STAT_ELEMENT}},
    '{'{spse_pkg::REQ_INTERSECT, 1'b1, 32'hffffffff}, '{1'b1, 1'b1, spse_pkg::STAT_ELEMENT}},
    '{'{spse_pkg::REQ_REMOVE, 1'b0, 32'h5}, '{1'b1, 1'b0, spse_pkg::STAT_ABSENT}},
    '{'{spse_pkg::REQ_ADD, 1'b0, 32'h7fffffff}, '{1'b1, 1'b0, spse_pkg::STAT_ADDED}},
    '{'{spse_pkg::REQ_ADD, 1'b0, 32'h80000000}, '{1'b1, 1'b0, spse_pkg::STAT_ADDED}},
    '{'{spse_pkg::REQ_ADD, 1'b0, 32'h0}, '{1'b1, 1'b0, spse_pkg::STAT_ADDED}},
    '{'{spse_pkg::REQ_ADD, 1'b0, 32'h80000000}, '{1'b1, 1'b0, spse_pkg::STAT_PRESENT}},
    '{'{spse_pkg::REQ_ADD, 1'b1, 32'hffffffff}, '{1'b1, 1'b0, spse_pkg::STAT_ADDED}},
    '{'{spse_pkg::REQ_ADD, 1'b1, 32'h7fffffff}, '{1'b1, 1'b0, spse_pkg::STAT_ADDED}},
    '{'{spse_pkg::REQ_ADD, 1'b1, 32'h1}, '{1'b1, 1'b0, spse_pkg::STAT_ADDED}},
    '{'{spse_pkg::REQ_PRINT, 1'b0, 32'h0}, '{1'b0, 1'b0, spse_pkg::STAT_ELEMENT}},
    '{'{spse_pkg::REQ_PRINT, 1'b1, 32'h0}, '{1'b0, 1'b0, spse_pkg::STAT_ELEMENT}},
    '{'{spse_pkg::REQ_UNION, 1'b1, 32'h12345678}, '{1'b0, 1'b0, spse_pkg::STAT_ELEMENT}},
    '{'{spse_pkg::REQ_INTERSECT, 1'b0, 32'h0}, '{1'b0, 1'b0, spse_pkg::STAT_ELEMENT}},
    '{'{spse_pkg::REQ_REMOVE, 1'b0, 32'h0}, '{1'b1, 1'b0, spse_pkg::STAT_REMOVED}},
    '{'{spse_pkg::REQ_REMOVE, 1'b0, 32'h0}, '{1'b1, 1'b0, spse_pkg::STAT_ABSENT}},
    '{'{spse_pkg::REQ_REMOVE, 1'b1, 32'h7fffffff}, '{1'b1, 1'b0, spse_pkg::STAT_REMOVED}},
    '{'{REQ_RSVD5, 1'b0, 32'h7fffffff}, '{1'b1, 1'b1, spse_pkg::STAT_ELEMENT}},
    '{'{REQ_RSVD6, 1'b1, 32'h80000000}, '{1'b1, 1'b1, spse_pkg::STAT_ELEMENT}},
    '{'{REQ_RSVD7, 1'b1, 32'h1}, '{1'b1, 1'b1, spse_pkg::STAT_ELEMENT}},
    '{'{spse_pkg::REQ_UNION, 1'b0, 32'hffffffff}, '{1'b0, 1'b0, spse_pkg::STAT_ELEMENT}}
  };

  sorted_pair_set_engine_top dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req    (req),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic int find_entry(input int s, input logic signed [31:0] v);
    for (int i = 0; i < set_cnt[s]; i++)
      if (set_mem[s][i] == v) return i;
    return -1;
  endfunction

  task automatic emit_result(input logic signed [31:0] e, input logic [2:0] st);
    if (request_results.size() < spse_pkg::MAX_RESULTS)
      request_results.push_back('{e, st, 1'b0});
  endtask

  // updates the predicted sets and fills request_results
  task automatic apply_set_request(input spse_pkg::req_t r);
    int s, pos, i, j;
    logic signed [31:0] v, a, b;
    s = int'(r.set_select);
    v = r.value;
    i = 0;
    j = 0;
    request_results.delete();
    case (r.req_type)
      spse_pkg::REQ_ADD: begin
        pos = find_entry(s, v);
        if (pos >= 0) begin
          emit_result('0, spse_pkg::STAT_PRESENT);
        end else if (set_cnt[s] >= CAP) begin
          emit_result('0, spse_pkg::STAT_FULL);
        end else begin
          i = set_cnt[s];
          while (i > 0 && v < set_mem[s][i-1]) begin
            set_mem[s][i] = set_mem[s][i-1];
            i--;
          end
          set_mem[s][i] = v;
          set_cnt[s]++;
          emit_result('0, spse_pkg::STAT_ADDED);
        end
      end
      spse_pkg::REQ_REMOVE: begin
        pos = find_entry(s, v);
        if (pos < 0) begin
          emit_result('0, spse_pkg::STAT_ABSENT);
        end else begin
          for (int k = pos; k + 1 < set_cnt[s]; k++) set_mem[s][k] = set_mem[s][k+1];
          set_cnt[s]--;
          emit_result('0, spse_pkg::STAT_REMOVED);
        end
      end
      spse_pkg::REQ_PRINT: begin
        for (int k = 0; k < set_cnt[s]; k++)
          emit_result(set_mem[s][k], spse_pkg::STAT_ELEMENT);
      end
      spse_pkg::REQ_UNION, spse_pkg::REQ_INTERSECT: begin
        while (i < set_cnt[0] && j < set_cnt[1]) begin
          a = set_mem[0][i];
          b = set_mem[1][j];
          if (a < b) begin
            if (r.req_type == spse_pkg::REQ_UNION) emit_result(a, spse_pkg::STAT_ELEMENT);
            i++;
          end else if (b < a) begin
            if (r.req_type == spse_pkg::REQ_UNION) emit_result(b, spse_pkg::STAT_ELEMENT);
            j++;
          end else begin
            emit_result(a, spse_pkg::STAT_ELEMENT);
            i++;
            j++;
          end
        end
        if (r.req_type == spse_pkg::REQ_UNION) begin
          for (; i < set_cnt[0]; i++) emit_result(set_mem[0][i], spse_pkg::STAT_ELEMENT);
          for (; j < set_cnt[1]; j++) emit_result(set_mem[1][j], spse_pkg::STAT_ELEMENT);
        end
      end
      default: ;
    endcase
    if (request_results.size() > 0) request_results[request_results.size()-1].last = 1'b1;
  endtask

  task automatic check_result(input spse_pkg::result_t got);
    spse_pkg::result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result element=%0d status=%0d last=%0b",
                                got.element, got.status, got.last));
    end else begin
      want = pending_results.pop_front();
      if (got.element !== want.element)
        report_mismatch($sformatf("element %0d, want %0d", got.element, want.element));
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
    end
  endtask

  // results are checked before the new transfer is predicted: they belong to older requests
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (strobe) check_result(result);
      if (start && !busy) begin
        cur_tag = request_tags.pop_front();
        apply_set_request(req);
        if (cur_tag.typed) begin
          if (!cur_tag.none) pending_results.push_back('{32'sd0, cur_tag.stat, 1'b1});
        end else begin
          foreach (request_results[k]) pending_results.push_back(request_results[k]);
        end
      end
      if ((start && !busy) || strobe) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("sorted_pair_set_engine_top regression: fail");
        $finish;
      end
    end
  end

  task automatic send_request(input spse_pkg::req_t r, input tag_t t, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request_tags.push_back(t);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0 || busy);
  endtask

  task automatic refresh_pool();
    value_pool[0] = 32'sh80000000;
    value_pool[1] = 32'sh7fffffff;
    value_pool[2] = 32'sd0;
    value_pool[3] = -32'sd1;
    value_pool[4] = 32'sd1;
    for (int k = 5; k < POOL_N; k++)
      value_pool[k] = (k % 2) ? 32'($urandom) : 32'($urandom_range(0, 64)) - 32'sd32;
  endtask

  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(0, 4) == 0) return 32'($urandom);
    return value_pool[$urandom_range(0, POOL_N - 1)];
  endfunction

  // removes mostly target values that are present
  function automatic logic signed [31:0] pick_victim(input int s);
    if (set_cnt[s] > 0 && $urandom_range(0, 2) != 0)
      return set_mem[s][$urandom_range(0, set_cnt[s] - 1)];
    return pick_value();
  endfunction

  function automatic spse_pkg::req_t random_request(input int mode);
    spse_pkg::req_t r;
    int roll, add_t, rem_t, prn_t, uni_t, isc_t;
    roll = $urandom_range(0, 99);
    r.set_select = 1'($urandom_range(0, 1));
    r.value = 32'($urandom);
    case (mode)
      MODE_FILL:  begin add_t = 70; rem_t = 78; prn_t = 85; uni_t = 91; isc_t = 97; end
      MODE_DRAIN: begin add_t = 15; rem_t = 65; prn_t = 75; uni_t = 85; isc_t = 95; end
      default:    begin add_t = 35; rem_t = 60; prn_t = 72; uni_t = 82; isc_t = 94; end
    endcase
    if (roll < add_t) begin
      r.req_type = spse_pkg::REQ_ADD;
      r.value = pick_value();
    end else if (roll < rem_t) begin
      r.req_type = spse_pkg::REQ_REMOVE;
      r.value = pick_victim(int'(r.set_select));
    end else if (roll < prn_t) begin
      r.req_type = spse_pkg::REQ_PRINT;
    end else if (roll < uni_t) begin
      r.req_type = spse_pkg::REQ_UNION;
    end else if (roll < isc_t) begin
      r.req_type = spse_pkg::REQ_INTERSECT;
    end else begin
      r.req_type = 3'(REQ_RSVD5 + $urandom_range(0, 2));
    end
    return r;
  endfunction

  initial begin
    spse_pkg::req_t r;
    int   sent, mode;
    bit   no_idle;
    set_cnt[0] = 0;
    set_cnt[1] = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tbl[k]) send_request(dir_tbl[k].r, dir_tbl[k].tag, $urandom_range(0, 5));
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      mode = p % 3;
      no_idle = ($urandom_range(0, 2) == 0);
      refresh_pool();
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        r = random_request(mode);
        send_request(r, '0, no_idle ? 0 : $urandom_range(0, 5));
        if (r.req_type <= spse_pkg::REQ_INTERSECT) sent++;
      end
      // on odd phases, hold off until the block has delivered everything
      if (p % 2 == 1) wait_drained();
    end

    wait_drained();
    repeat (2 * CAP + 8) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (mismatch_count == 0) begin
      $display("sorted_pair_set_engine_top regression: pass");
    end else begin
      $display("sorted_pair_set_engine_top regression: fail");
    end
    $finish;
  end

endmodule
